### sv/bspl_pkg.sv
`default_nettype none
package bspl_pkg;

   localparam int MAX_NODES = 4096;
   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int VISIT_W = $clog2(MAX_NODES + 1);
   localparam int COUNT_W = 13;
   localparam int LINK_W = 16;
   localparam int SUB_W = 15;
   localparam int FRAC_BITS = 16;
   localparam int LEAF_BIT = 15;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic signed [31:0] ox;
      logic signed [31:0] oy;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
      logic [LINK_W-1:0] child_back;
      logic [LINK_W-1:0] child_front;
   } bspl_node_type;

   typedef struct packed {
      logic write_node;
      logic load_query;
      logic read_node;
      logic sub_step;
      logic mul_step;
      logic emit;
      logic emit_error;
   } bspl_cmd_type;

   typedef struct packed {
      logic leaf;
      logic bound_fail;
      logic out_busy;
   } bspl_stat_type;

endpackage
`default_nettype wire

### sv/bspl_req_if.sv
`default_nettype none
interface bspl_req_if;
   logic valid;
   logic ready;
   logic command;
   logic [11:0] node_index;
   logic signed [31:0] line_x;
   logic signed [31:0] line_y;
   logic signed [31:0] line_dx;
   logic signed [31:0] line_dy;
   logic [15:0] child_front;
   logic [15:0] child_back;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;

   modport source (
      output valid, command, node_index, line_x, line_y, line_dx, line_dy,
             child_front, child_back, point_x, point_y,
      input ready
   );
   modport sink (
      input valid, command, node_index, line_x, line_y, line_dx, line_dy,
            child_front, child_back, point_x, point_y,
      output ready
   );
endinterface
`default_nettype wire

### sv/bspl_rsp_if.sv
`default_nettype none
interface bspl_rsp_if;
   logic valid;
   logic ready;
   logic [14:0] subsector_index;
   logic walk_error;

   modport source (output valid, subsector_index, walk_error, input ready);
   modport sink (input valid, subsector_index, walk_error, output ready);
endinterface
`default_nettype wire

### sv/bsp_point_locator.sv
`default_nettype none
// channel   dir   beat content
// req_if    in    command, node_index, line_*, child_front/back, point_x/y
// rsp_if    out   subsector_index, walk_error (one beat per query)
// csr_*     in    node_count, written with csr_wr_en
//
// Per node visited, a query makes one node-memory read, one subtract stage
// and one 16x16 multiply stage. Reset clears control and node_count only;
// the node memory is not cleared. A finished result waits in the output
// register; the next item is accepted meanwhile, and a query that finishes
// while a beat is still untaken holds.
module bsp_point_locator (
   input wire logic clock,
   input wire logic reset,
   bspl_req_if.sink req_if,
   bspl_rsp_if.source rsp_if,
   input wire logic csr_wr_en,
   input wire logic [bspl_pkg::COUNT_W-1:0] csr_wr_data
);

   bspl_pkg::bspl_cmd_type cmd;
   bspl_pkg::bspl_stat_type stat;

   bspl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .req (req_if),
      .stat (stat),
      .cmd (cmd)
   );

   bspl_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req (req_if),
      .rsp (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd (cmd),
      .stat (stat)
   );

endmodule
`default_nettype wire

### sv/bspl_ctrl.sv
`default_nettype none
module bspl_ctrl (
   input wire logic clock,
   input wire logic reset,
   bspl_req_if.sink req,
   input wire bspl_pkg::bspl_stat_type stat,
   output bspl_pkg::bspl_cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SUB = 2'd2;
   localparam logic [1:0] S_MUL = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [bspl_pkg::VISIT_W-1:0] visits_ff;
   logic [bspl_pkg::VISIT_W-1:0] visits_in;
   logic walk_fail;

   assign req.ready = (state_ff == S_IDLE);
   assign walk_fail = stat.bound_fail
                    || (visits_ff >= bspl_pkg::VISIT_W'(bspl_pkg::MAX_NODES));

   always_comb begin
      state_in = state_ff;
      visits_in = visits_ff;
      cmd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               if (req.command == bspl_pkg::CMD_WRITE) begin
                  cmd.write_node = 1'b1;
               end else begin
                  cmd.load_query = 1'b1;
                  visits_in = '0;
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (stat.leaf || walk_fail) begin
               // hold until the output register can take the result
               if (!stat.out_busy) begin
                  cmd.emit = 1'b1;
                  cmd.emit_error = !stat.leaf;
                  state_in = S_IDLE;
               end
            end else begin
               cmd.read_node = 1'b1;
               visits_in = visits_ff + 1'b1;
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            cmd.sub_step = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            state_in = S_CHECK;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         visits_ff <= '0;
      end else begin
         state_ff <= state_in;
         visits_ff <= visits_in;
      end
   end

   a_visit_bound: assert property (@(posedge clock) disable iff (reset)
      visits_ff <= bspl_pkg::VISIT_W'(bspl_pkg::MAX_NODES))
      else $error("visit counter passed the node bound");

   a_read_checked: assert property (@(posedge clock) disable iff (reset)
      cmd.read_node |-> !stat.leaf && !stat.bound_fail)
      else $error("node read issued on a leaf or out-of-range link");

   a_walk_cycle: assert property (@(posedge clock) disable iff (reset)
      cmd.read_node |=> cmd.sub_step ##1 cmd.mul_step)
      else $error("node step sequence broken");

endmodule
`default_nettype wire

### sv/bspl_datapath.sv
`default_nettype none
module bspl_datapath (
   input wire logic clock,
   input wire logic reset,
   bspl_req_if.sink req,
   bspl_rsp_if.source rsp,
   input wire logic csr_wr_en,
   input wire logic [bspl_pkg::COUNT_W-1:0] csr_wr_data,
   input wire bspl_pkg::bspl_cmd_type cmd,
   output bspl_pkg::bspl_stat_type stat
);

   bspl_pkg::bspl_node_type node_mem [bspl_pkg::MAX_NODES];
   bspl_pkg::bspl_node_type rd_ff;

   logic [bspl_pkg::COUNT_W-1:0] node_count_ff;
   logic signed [31:0] px_ff;
   logic signed [31:0] py_ff;
   logic [bspl_pkg::LINK_W-1:0] cur_ff;
   logic [bspl_pkg::LINK_W-1:0] cur_in;

   logic signed [15:0] ddx_hi_ff;
   logic signed [15:0] ddy_hi_ff;
   logic dx_zero_ff;
   logic dy_zero_ff;
   logic back_x_ff;
   logic back_y_ff;

   logic rsp_valid_ff;
   logic [bspl_pkg::SUB_W-1:0] rsp_sub_ff;
   logic rsp_err_ff;

   logic signed [31:0] ddx;
   logic signed [31:0] ddy;
   logic signed [15:0] dx_hi;
   logic signed [15:0] dy_hi;
   logic signed [31:0] left_prod;
   logic signed [31:0] right_prod;
   logic go_back;
   logic write_ok;

   assign write_ok = ({5'd0, req.node_index} < 17'(bspl_pkg::MAX_NODES));

   always_ff @(posedge clock) begin
      if (cmd.write_node && write_ok) begin
         node_mem[req.node_index[bspl_pkg::NODE_AW-1:0]] <= '{
            ox: req.line_x, oy: req.line_y, dx: req.line_dx, dy: req.line_dy,
            child_back: req.child_back, child_front: req.child_front};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.read_node) begin
         rd_ff <= node_mem[cur_ff[bspl_pkg::NODE_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // side test, first half: offsets and the axis-aligned decisions
   assign ddx = px_ff - rd_ff.ox;
   assign ddy = py_ff - rd_ff.oy;

   always_ff @(posedge clock) begin
      if (cmd.sub_step) begin
         ddx_hi_ff <= ddx[31:bspl_pkg::FRAC_BITS];
         ddy_hi_ff <= ddy[31:bspl_pkg::FRAC_BITS];
         dx_zero_ff <= (rd_ff.dx == 32'sd0);
         dy_zero_ff <= (rd_ff.dy == 32'sd0);
         back_x_ff <= (px_ff <= rd_ff.ox) ? (rd_ff.dy > 32'sd0) : (rd_ff.dy < 32'sd0);
         back_y_ff <= (py_ff <= rd_ff.oy) ? (rd_ff.dx < 32'sd0) : (rd_ff.dx > 32'sd0);
      end
   end

   // second half: integer-part cross products
   assign dx_hi = rd_ff.dx[31:bspl_pkg::FRAC_BITS];
   assign dy_hi = rd_ff.dy[31:bspl_pkg::FRAC_BITS];
   assign left_prod = dy_hi * ddx_hi_ff;
   assign right_prod = ddy_hi_ff * dx_hi;

   always_comb begin
      if (dx_zero_ff) begin
         go_back = back_x_ff;
      end else if (dy_zero_ff) begin
         go_back = back_y_ff;
      end else begin
         go_back = !(right_prod < left_prod);
      end
   end

   always_comb begin
      cur_in = cur_ff;
      if (cmd.load_query) begin
         if (node_count_ff == '0) begin
            // empty tree: walk straight to subsector 0
            cur_in = bspl_pkg::LINK_W'(1) << bspl_pkg::LEAF_BIT;
         end else begin
            cur_in = bspl_pkg::LINK_W'(node_count_ff - 1'b1);
         end
      end else if (cmd.mul_step) begin
         cur_in = go_back ? rd_ff.child_back : rd_ff.child_front;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.load_query) begin
         px_ff <= req.point_x;
         py_ff <= req.point_y;
      end
   end

   assign stat.leaf = cur_ff[bspl_pkg::LEAF_BIT];
   assign stat.bound_fail = (cur_ff >= bspl_pkg::LINK_W'(node_count_ff))
                         || (cur_ff >= bspl_pkg::LINK_W'(bspl_pkg::MAX_NODES));
   assign stat.out_busy = rsp_valid_ff && !rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_err_ff <= cmd.emit_error;
         rsp_sub_ff <= cmd.emit_error ? '0 : cur_ff[bspl_pkg::SUB_W-1:0];
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.subsector_index = rsp_sub_ff;
   assign rsp.walk_error = rsp_err_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !stat.out_busy)
      else $error("result loaded over an untaken beat");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.emit_error |=> rsp_err_ff && (rsp_sub_ff == '0))
      else $error("failed walk must report subsector zero");

endmodule
`default_nettype wire
